// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BSCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BSCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/bsca_pkg.sv
`timescale 1ns / 1ps
package bsca_pkg;

  localparam int COLOR_W = 8;
  localparam int POS_W   = 11;
  localparam int DB_W    = 10;
  localparam int FSZ_W   = 12;
  localparam int SUM_W   = 34;
  localparam int CNT_W   = 23;
  localparam int CMD_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_ROWS = 2048;
  localparam int DEF_MAX_COLS = 2048;

  localparam logic [COLOR_W-1:0] RST_RED_THR   = 8'd240;
  localparam logic [COLOR_W-1:0] RST_GREEN_THR = 8'd190;
  localparam logic [COLOR_W-1:0] RST_BLUE_THR  = 8'd220;
  localparam logic [DB_W-1:0]    RST_DEADBAND  = 10'd40;
  localparam logic [FSZ_W-1:0]   RST_ROWS      = 12'd480;
  localparam logic [FSZ_W-1:0]   RST_COLS      = 12'd640;

  localparam logic [CNT_W-1:0] HIT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 3'd0,
    CMD_DOWN  = 3'd1,
    CMD_UP    = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_RIGHT = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_THR   = 3'd0,
    REG_GREEN_THR = 3'd1,
    REG_BLUE_THR  = 3'd2,
    REG_DEADBAND  = 3'd3,
    REG_ROWS      = 3'd4,
    REG_COLS      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [COLOR_W-1:0] red_thr;
    logic [COLOR_W-1:0] green_thr;
    logic [COLOR_W-1:0] blue_thr;
    logic [DB_W-1:0]    deadband;
    logic [FSZ_W-1:0]   frame_rows;
    logic [FSZ_W-1:0]   frame_cols;
  } cfg_t;

  // Per-frame totals handed from front to back.
  typedef struct packed {
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] col_sum;
    logic [CNT_W-1:0] count;
  } frame_t;

endpackage

// File: hdl/bsca_if.sv
`timescale 1ns / 1ps
interface bsca_pix_if;
  logic                          valid;
  logic                          ready;
  logic [bsca_pkg::COLOR_W-1:0] blue;
  logic [bsca_pkg::COLOR_W-1:0] green;
  logic [bsca_pkg::COLOR_W-1:0] red;
  logic [bsca_pkg::POS_W-1:0]   row;
  logic [bsca_pkg::POS_W-1:0]   col;
  logic                          frame_end;

  modport source (output valid, blue, green, red, row, col, frame_end, input ready);
  modport sink   (input valid, blue, green, red, row, col, frame_end, output ready);
endinterface

interface bsca_res_if;
  logic                        valid;
  logic                        ready;
  logic [bsca_pkg::CMD_W-1:0] command;
  logic [bsca_pkg::POS_W-1:0] centroid_row;
  logic [bsca_pkg::POS_W-1:0] centroid_col;
  logic [bsca_pkg::CNT_W-1:0] hits;

  modport source (output valid, command, centroid_row, centroid_col, hits, input ready);
  modport sink   (input valid, command, centroid_row, centroid_col, hits, output ready);
endinterface

// File: hdl/bsca_front.sv
`timescale 1ns / 1ps
module bsca_front #(
  parameter int MAX_ROWS = bsca_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bsca_pkg::DEF_MAX_COLS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsca_pkg::cfg_t      cfg_i,
  bsca_pix_if.sink            pix_i,
  input  logic                q_full_i,
  output logic                push_o,
  output bsca_pkg::frame_t    push_data_o
);

  // 13 bits cover the whole parameter range (up to 4096)
  localparam logic [12:0] ROW_LIM = 13'(MAX_ROWS);
  localparam logic [12:0] COL_LIM = 13'(MAX_COLS);

  logic [bsca_pkg::SUM_W-1:0] row_sum_q, row_sum_d, row_sum_upd;
  logic [bsca_pkg::SUM_W-1:0] col_sum_q, col_sum_d, col_sum_upd;
  logic [bsca_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_upd;
  logic                       accept, hit, take;

  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign hit = (pix_i.red > cfg_i.red_thr) && (pix_i.green > cfg_i.green_thr) &&
               (pix_i.blue > cfg_i.blue_thr) &&
               ({2'b00, pix_i.row} < ROW_LIM) && ({2'b00, pix_i.col} < COL_LIM);

  // saturated count: further hits of the frame are dropped
  assign take = hit && (cnt_q != bsca_pkg::HIT_MAX);

  always_comb begin
    row_sum_upd = row_sum_q;
    col_sum_upd = col_sum_q;
    cnt_upd     = cnt_q;
    if (take) begin
      row_sum_upd = row_sum_q + {{(bsca_pkg::SUM_W-bsca_pkg::POS_W){1'b0}}, pix_i.row};
      col_sum_upd = col_sum_q + {{(bsca_pkg::SUM_W-bsca_pkg::POS_W){1'b0}}, pix_i.col};
      cnt_upd     = cnt_q + 1'b1;
    end
  end

  always_comb begin
    row_sum_d = row_sum_q;
    col_sum_d = col_sum_q;
    cnt_d     = cnt_q;
    if (accept) begin
      if (pix_i.frame_end) begin
        row_sum_d = '0;
        col_sum_d = '0;
        cnt_d     = '0;
      end else begin
        row_sum_d = row_sum_upd;
        col_sum_d = col_sum_upd;
        cnt_d     = cnt_upd;
      end
    end
  end

  assign push_o              = accept && pix_i.frame_end;
  assign push_data_o.row_sum = row_sum_upd;
  assign push_data_o.col_sum = col_sum_upd;
  assign push_data_o.count   = cnt_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
      col_sum_q <= '0;
      cnt_q     <= '0;
    end else begin
      row_sum_q <= row_sum_d;
      col_sum_q <= col_sum_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

// File: hdl/bsca_queue.sv
`timescale 1ns / 1ps
module bsca_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bsca_pkg::frame_t push_data_i,
  input  logic             pop_i,
  output bsca_pkg::frame_t pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(bsca_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(bsca_pkg::QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(bsca_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(bsca_pkg::QUEUE_DEPTH - 1);

  bsca_pkg::frame_t  slot_q [bsca_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == FILL_MAX);
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) fill_d = fill_q + 1'b1;
    else if (do_pop && !do_push) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: hdl/bsca_back.sv
`timescale 1ns / 1ps
module bsca_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsca_pkg::cfg_t   cfg_i,
  input  logic             q_empty_i,
  input  bsca_pkg::frame_t q_data_i,
  output logic             pop_o,
  bsca_res_if.source       res_o
);

  localparam int QW    = bsca_pkg::POS_W;            // quotient bits
  localparam int REM_W = bsca_pkg::CNT_W + 1;
  localparam int STEP_W = $clog2(QW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);
  localparam int SW = bsca_pkg::FSZ_W + 1;           // signed compare width

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [REM_W-1:0]            rem_r_q, rem_r_d, rem_c_q, rem_c_d;
  logic [QW-1:0]               quo_r_q, quo_r_d, quo_c_q, quo_c_d;
  logic [bsca_pkg::CNT_W-1:0]  div_q, div_d;
  logic [REM_W-1:0]            trial_r, trial_c;
  logic                        ge_r, ge_c, out_free, load_out;

  logic                        out_valid_q, out_valid_d;
  logic [bsca_pkg::CMD_W-1:0]  cmd_q;
  logic [QW-1:0]               crow_q, ccol_q;
  logic [bsca_pkg::CNT_W-1:0]  hits_q;

  logic signed [SW-1:0] cr, cc, db, crow_s, ccol_s;
  bsca_pkg::cmd_e       cmd;

  assign out_free = !out_valid_q || res_o.ready;

  // one quotient bit per cycle for row and column in parallel;
  // mean of 11-bit positions fits 11 bits, so the top 23 dividend bits
  // start as the partial remainder
  assign trial_r = {rem_r_q[REM_W-2:0], quo_r_q[QW-1]};
  assign trial_c = {rem_c_q[REM_W-2:0], quo_c_q[QW-1]};
  assign ge_r    = trial_r >= {1'b0, div_q};
  assign ge_c    = trial_c >= {1'b0, div_q};

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    rem_r_d  = rem_r_q;
    rem_c_d  = rem_c_q;
    quo_r_d  = quo_r_q;
    quo_c_d  = quo_c_q;
    div_d    = div_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          div_d   = q_data_i.count;
          rem_r_d = {1'b0, q_data_i.row_sum[bsca_pkg::SUM_W-1:QW]};
          rem_c_d = {1'b0, q_data_i.col_sum[bsca_pkg::SUM_W-1:QW]};
          quo_r_d = q_data_i.row_sum[QW-1:0];
          quo_c_d = q_data_i.col_sum[QW-1:0];
          step_d  = '0;
          state_d = (q_data_i.count == '0) ? S_LOAD : S_DIV;
        end
      end
      S_DIV: begin
        rem_r_d = ge_r ? trial_r - {1'b0, div_q} : trial_r;
        rem_c_d = ge_c ? trial_c - {1'b0, div_q} : trial_c;
        quo_r_d = {quo_r_q[QW-2:0], ge_r};
        quo_c_d = {quo_c_q[QW-2:0], ge_c};
        step_d  = step_q + 1'b1;
        if (step_q == STEP_LAST) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // steering: row before column, signed so a negative bound never fires
  assign cr     = SW'({1'b0, cfg_i.frame_rows[bsca_pkg::FSZ_W-1:1]});
  assign cc     = SW'({1'b0, cfg_i.frame_cols[bsca_pkg::FSZ_W-1:1]});
  assign db     = SW'(cfg_i.deadband);
  assign crow_s = SW'(quo_r_q);
  assign ccol_s = SW'(quo_c_q);

  always_comb begin
    priority if (div_q == '0) cmd = bsca_pkg::CMD_NONE;
    else if (crow_s < cr - db) cmd = bsca_pkg::CMD_DOWN;
    else if (crow_s > cr + db) cmd = bsca_pkg::CMD_UP;
    else if (ccol_s < cc - db) cmd = bsca_pkg::CMD_LEFT;
    else if (ccol_s > cc + db) cmd = bsca_pkg::CMD_RIGHT;
    else cmd = bsca_pkg::CMD_NONE;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) out_valid_d = 1'b0;
    if (load_out)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    rem_r_q <= rem_r_d;
    rem_c_q <= rem_c_d;
    quo_r_q <= quo_r_d;
    quo_c_q <= quo_c_d;
    div_q   <= div_d;
    if (load_out) begin
      cmd_q  <= cmd;
      crow_q <= (div_q == '0) ? '0 : quo_r_q;
      ccol_q <= (div_q == '0) ? '0 : quo_c_q;
      hits_q <= div_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.command      = cmd_q;
  assign res_o.centroid_row = crow_q;
  assign res_o.centroid_col = ccol_q;
  assign res_o.hits         = hits_q;

endmodule

// File: hdl/bright_spot_centroid_aim_top.sv
`timescale 1ns / 1ps
// Bright-spot centroid aim.
// pix_i: one pixel item per cycle while ready (blue, green, red, row, col,
//   frame_end), valid/ready; a hit has all three channels above thresholds.
// res_o: one result item per frame (command, centroid_row, centroid_col,
//   hits), issued for the pixel that carries frame_end.
// cfg: cfg_we_i/cfg_idx_i/cfg_data_i write one register per cycle; write
//   only while no frame result is pending.
// Throughput: the front takes one pixel every cycle while the queue is not
//   full. The back end works on one frame at a time (pop, 11 divide steps,
//   output load; a frame with no hits skips the divide steps), using the
//   bit-serial divider; two finished frames can wait in the queue.
// A taken frame_end pixel's totals pass through the queue, the divider and
//   the output register before res_o.valid rises.
// Stall: if res_o is held off, the output register keeps its item, the back
//   end finishes its division and waits, and pixels keep flowing until the
//   queue fills; then pix_i.ready drops.
// Reset: thresholds 240/190/220, deadband 40, frame 480 x 640, sums cleared,
//   queue and output empty.
module bright_spot_centroid_aim_top #(
  parameter int MAX_ROWS = bsca_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bsca_pkg::DEF_MAX_COLS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bsca_pix_if.sink                          pix_i,
  bsca_res_if.source                        res_o,
  input  logic                              cfg_we_i,
  input  logic [bsca_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bsca_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  bsca_pkg::cfg_t   cfg_q, cfg_d;
  bsca_pkg::frame_t push_data, pop_data;
  logic             push, pop, q_full, q_empty;

  // register file; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsca_pkg::REG_RED_THR:   cfg_d.red_thr    = cfg_data_i[bsca_pkg::COLOR_W-1:0];
        bsca_pkg::REG_GREEN_THR: cfg_d.green_thr  = cfg_data_i[bsca_pkg::COLOR_W-1:0];
        bsca_pkg::REG_BLUE_THR:  cfg_d.blue_thr   = cfg_data_i[bsca_pkg::COLOR_W-1:0];
        bsca_pkg::REG_DEADBAND:  cfg_d.deadband   = cfg_data_i[bsca_pkg::DB_W-1:0];
        bsca_pkg::REG_ROWS:      cfg_d.frame_rows = cfg_data_i[bsca_pkg::FSZ_W-1:0];
        bsca_pkg::REG_COLS:      cfg_d.frame_cols = cfg_data_i[bsca_pkg::FSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_thr    <= bsca_pkg::RST_RED_THR;
      cfg_q.green_thr  <= bsca_pkg::RST_GREEN_THR;
      cfg_q.blue_thr   <= bsca_pkg::RST_BLUE_THR;
      cfg_q.deadband   <= bsca_pkg::RST_DEADBAND;
      cfg_q.frame_rows <= bsca_pkg::RST_ROWS;
      cfg_q.frame_cols <= bsca_pkg::RST_COLS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify and accumulate, hand frame totals to the queue
  bsca_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_i       (pix_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bsca_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back: divide, steer, hold the result
  bsca_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

// File: hdl/bsca_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsca_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pix_valid_i,
  input logic                        pix_ready_i,
  input logic                        pix_frame_end_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [bsca_pkg::CMD_W-1:0]  res_command_i,
  input logic [bsca_pkg::POS_W-1:0]  res_crow_i,
  input logic [bsca_pkg::POS_W-1:0]  res_ccol_i,
  input logic [bsca_pkg::CNT_W-1:0]  res_hits_i
);

  logic [3:0] pend_q, pend_d;
  logic       fin, fout, stall, no_hits, empty_ok;
  logic [bsca_pkg::CMD_W+2*bsca_pkg::POS_W+bsca_pkg::CNT_W-1:0] res_pay;

  assign fin      = pix_valid_i && pix_ready_i && pix_frame_end_i;
  assign fout     = res_valid_i && res_ready_i;
  assign stall    = res_valid_i && !res_ready_i;
  assign res_pay  = {res_command_i, res_crow_i, res_ccol_i, res_hits_i};
  assign no_hits  = res_valid_i && (res_hits_i == '0);
  assign empty_ok = (res_command_i == bsca_pkg::CMD_NONE) && (res_crow_i == '0) &&
                    (res_ccol_i == '0);

  always_comb begin
    pend_d = pend_q;
    if (fin && !fout) pend_d = pend_q + 1'b1;
    else if (fout && !fin) pend_d = pend_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_d;
  end

  `BSCA_ASSERT(a_res_hold, stall |=> res_valid_i && $stable(res_pay), "stalled result changed")
  `BSCA_ASSERT(a_empty_frame, no_hits |-> empty_ok, "empty frame gave nonzero result")
  `BSCA_ASSERT(a_no_phantom, res_valid_i |-> pend_q != '0, "result without a finished frame")
  `BSCA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !res_valid_i, "result valid right after reset")

endmodule

bind bright_spot_centroid_aim_top bsca_checker u_bsca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pix_valid_i     (pix_i.valid),
  .pix_ready_i     (pix_i.ready),
  .pix_frame_end_i (pix_i.frame_end),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_command_i   (res_o.command),
  .res_crow_i      (res_o.centroid_row),
  .res_ccol_i      (res_o.centroid_col),
  .res_hits_i      (res_o.hits)
);

// File: test/bright_spot_centroid_aim_top_test.sv
`timescale 1ns / 1ps
module bright_spot_centroid_aim_top_test;
  import bsca_pkg::*;

  // Run shape
  localparam int PIXEL_TARGET = 550;
  localparam int QUIET_ITEMS  = 70;    // last stretch runs without idling
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 300;   // long result back-pressure window
  localparam int TAIL_LIMIT   = 5000;

  // Register indexes the block does not decode; writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    cmd_e               command;
    logic [POS_W-1:0]   crow;
    logic [POS_W-1:0]   ccol;
    logic [CNT_W-1:0]   hits;
  } aim_t;

  // One directed step: the pixel, and a typed expectation where the answer
  // is obvious by inspection. Untyped rows go through the predictor.
  typedef struct packed {
    pixel_t px;
    logic   typed;
    aim_t   want;
  } dir_row_t;

  localparam int N_DIRECTED = 20;

  // Reset config: thresholds r240 g190 b220, deadband 40, center (240, 320).
  // Columns:          blue     green    red      row        col       end
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // empty frame: no hits, everything zero
    '{'{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    1'b1}, 1'b1,
      '{CMD_NONE,  11'd0,    11'd0,    23'd0}},
    // corners and edges: one hit per frame drives each command
    '{'{8'd255, 8'd255, 8'd255, 11'd0,    11'd0,    1'b1}, 1'b1,
      '{CMD_DOWN,  11'd0,    11'd0,    23'd1}},
    '{'{8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b1}, 1'b1,
      '{CMD_UP,    11'd2047, 11'd2047, 23'd1}},
    '{'{8'd255, 8'd255, 8'd255, 11'd240,  11'd0,    1'b1}, 1'b1,
      '{CMD_LEFT,  11'd240,  11'd0,    23'd1}},
    '{'{8'd255, 8'd255, 8'd255, 11'd240,  11'd2047, 1'b1}, 1'b1,
      '{CMD_RIGHT, 11'd240,  11'd2047, 23'd1}},
    '{'{8'd255, 8'd255, 8'd255, 11'd240,  11'd320,  1'b1}, 1'b1,
      '{CMD_NONE,  11'd240,  11'd320,  23'd1}},
    // a channel sitting exactly on its threshold is not a hit
    '{'{8'd220, 8'd255, 8'd255, 11'd240,  11'd320,  1'b1}, 1'b1,
      '{CMD_NONE,  11'd0,    11'd0,    23'd0}},
    '{'{8'd255, 8'd190, 8'd255, 11'd240,  11'd320,  1'b1}, 1'b1,
      '{CMD_NONE,  11'd0,    11'd0,    23'd0}},
    '{'{8'd255, 8'd255, 8'd240, 11'd240,  11'd320,  1'b1}, 1'b1,
      '{CMD_NONE,  11'd0,    11'd0,    23'd0}},
    // one above each threshold; deadband edges are inclusive
    '{'{8'd221, 8'd191, 8'd241, 11'd200,  11'd280,  1'b1}, 1'b1,
      '{CMD_NONE,  11'd200,  11'd280,  23'd1}},
    '{'{8'd221, 8'd191, 8'd241, 11'd280,  11'd360,  1'b1}, 1'b1,
      '{CMD_NONE,  11'd280,  11'd360,  23'd1}},
    '{'{8'd221, 8'd191, 8'd241, 11'd199,  11'd320,  1'b1}, 1'b1,
      '{CMD_DOWN,  11'd199,  11'd320,  23'd1}},
    '{'{8'd221, 8'd191, 8'd241, 11'd240,  11'd361,  1'b1}, 1'b1,
      '{CMD_RIGHT, 11'd240,  11'd361,  23'd1}},
    // multi-pixel frame with a miss inside, truncating mean
    '{'{8'd255, 8'd255, 8'd255, 11'd100,  11'd100,  1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 11'd101,  11'd103,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd255, 11'd2047, 11'd2047, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 11'd102,  11'd104,  1'b1}, 1'b0, '0},
    // spread-out hits, mean lands between them
    '{'{8'd255, 8'd255, 8'd255, 11'd2047, 11'd0,    1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 11'd0,    11'd2047, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 11'd1,    11'd1,    1'b1}, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bsca_pix_if pix ();
  bsca_res_if res ();

  bright_spot_centroid_aim_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: register shadow plus the running frame sums.
  cfg_t             aim_cfg = '{RST_RED_THR, RST_GREEN_THR, RST_BLUE_THR,
                                RST_DEADBAND, RST_ROWS, RST_COLS};
  logic [SUM_W-1:0] row_total = '0;
  logic [SUM_W-1:0] col_total = '0;
  logic [CNT_W-1:0] hit_tally = '0;

  aim_t pending_aims [$];   // predicted frame results, oldest first
  int   mismatches  = 0;
  int   pixels_sent = 0;
  bit   quiet_tail  = 1'b0; // no idling on either side once set
  bit   hold_req    = 1'b0; // asks the result side for one long hold-off

  // Classify one pixel, update the sums and, on frame end, form the aim.
  function automatic void centroid_step(input pixel_t p, output bit done, output aim_t r);
    logic             is_hit;
    logic [SUM_W-1:0] mean_row, mean_col;
    int               cr, cc, db, yr, yc;
    is_hit = p.red > aim_cfg.red_thr && p.green > aim_cfg.green_thr &&
             p.blue > aim_cfg.blue_thr &&
             p.row < DEF_MAX_ROWS && p.col < DEF_MAX_COLS;
    // saturated count: further hits are dropped whole
    if (is_hit && hit_tally != HIT_MAX) begin
      row_total = row_total + p.row;
      col_total = col_total + p.col;
      hit_tally = hit_tally + 1'b1;
    end
    done = p.frame_end;
    r = '0;
    r.command = CMD_NONE;
    if (!p.frame_end) return;
    if (hit_tally != '0) begin
      mean_row = row_total / hit_tally;
      mean_col = col_total / hit_tally;
      // signed compare: a negative lower bound never fires
      cr = int'(aim_cfg.frame_rows >> 1);
      cc = int'(aim_cfg.frame_cols >> 1);
      db = int'(aim_cfg.deadband);
      yr = int'(mean_row);
      yc = int'(mean_col);
      if (yr < cr - db) r.command = CMD_DOWN;
      else if (yr > cr + db) r.command = CMD_UP;
      else if (yc < cc - db) r.command = CMD_LEFT;
      else if (yc > cc + db) r.command = CMD_RIGHT;
      r.crow = mean_row[POS_W-1:0];
      r.ccol = mean_col[POS_W-1:0];
      r.hits = hit_tally;
    end
    row_total = '0;
    col_total = '0;
    hit_tally = '0;
  endfunction

  // Mostly above threshold so frames carry hits; the rest is anything.
  function automatic logic [COLOR_W-1:0] channel_value(input logic [COLOR_W-1:0] thr);
    if (thr != 8'd255 && $urandom_range(0, 3) != 0)
      return COLOR_W'($urandom_range(int'(thr) + 1, 255));
    return COLOR_W'($urandom_range(0, 255));
  endfunction

  // Half uniform, half clustered around center so every command shows up.
  function automatic logic [POS_W-1:0] pick_pos(input int center, input int span);
    int v;
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 2047));
    v = center - span + int'($urandom_range(0, 2 * span));
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return POS_W'(v);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_RED_THR:   aim_cfg.red_thr    = data[COLOR_W-1:0];
      REG_GREEN_THR: aim_cfg.green_thr  = data[COLOR_W-1:0];
      REG_BLUE_THR:  aim_cfg.blue_thr   = data[COLOR_W-1:0];
      REG_DEADBAND:  aim_cfg.deadband   = data[DB_W-1:0];
      REG_ROWS:      aim_cfg.frame_rows = data[FSZ_W-1:0];
      REG_COLS:      aim_cfg.frame_cols = data[FSZ_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic idle_pixels(input int n);
    pix.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one pixel; valid stays high on return so back-to-back items
  // need no extra assignment.
  task automatic send_pixel(input pixel_t p, input logic typed, input aim_t want);
    bit   done;
    aim_t predicted;
    pix.valid     <= 1'b1;
    pix.blue      <= p.blue;
    pix.green     <= p.green;
    pix.red       <= p.red;
    pix.row       <= p.row;
    pix.col       <= p.col;
    pix.frame_end <= p.frame_end;
    do @(posedge clk_i); while (!pix.ready);
    centroid_step(p, done, predicted);
    if (done) pending_aims.push_back(typed ? want : predicted);
    pixels_sent++;
    if (pixels_sent >= PIXEL_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
  endtask

  // Block is idle once every frame result is back and the divider is done.
  task automatic settle_block();
    pix.valid <= 1'b0;
    while (pending_aims.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Pixel side: reset, directed rows, then config phases of random frames.
  initial begin : stimulus
    int     phase_no, phase_goal, phase_items, frame_len;
    bit     steady;
    pixel_t p;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    pix.valid     <= 1'b0;
    pix.blue      <= '0;
    pix.green     <= '0;
    pix.red       <= '0;
    pix.row       <= '0;
    pix.col       <= '0;
    pix.frame_end <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if ($urandom_range(0, 3) == 0) idle_pixels($urandom_range(1, 17));
      send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
    end

    phase_no = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      // sender holds off until every result is back, then reprograms
      settle_block();
      case (phase_no)
        0: begin
          // everything at its low end: center collapses to zero
          write_reg(REG_RED_THR, '0);
          write_reg(REG_GREEN_THR, '0);
          write_reg(REG_BLUE_THR, '0);
          write_reg(REG_DEADBAND, '0);
          write_reg(REG_ROWS, '0);
          write_reg(REG_COLS, '0);
        end
        1: begin
          // all ones: thresholds mask to 255 (no hits), oversize frame
          write_reg(REG_RED_THR, '1);
          write_reg(REG_GREEN_THR, '1);
          write_reg(REG_BLUE_THR, '1);
          write_reg(REG_DEADBAND, '1);
          write_reg(REG_ROWS, '1);
          write_reg(REG_COLS, '1);
        end
        2: begin
          // 1 x 1 frame, zero deadband
          write_reg(REG_RED_THR, CFG_DATA_W'($urandom_range(0, 200)));
          write_reg(REG_GREEN_THR, CFG_DATA_W'($urandom_range(0, 200)));
          write_reg(REG_BLUE_THR, CFG_DATA_W'($urandom_range(0, 200)));
          write_reg(REG_DEADBAND, '0);
          write_reg(REG_ROWS, CFG_DATA_W'(1));
          write_reg(REG_COLS, CFG_DATA_W'(1));
        end
        default: begin
          // upper data bits are random too; the block keeps the low bits
          write_reg(REG_RED_THR, CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(REG_GREEN_THR, CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(REG_BLUE_THR, CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(REG_DEADBAND, ($urandom_range(0, 3) == 0) ?
                    CFG_DATA_W'($urandom_range(0, 4095)) :
                    CFG_DATA_W'($urandom_range(0, 120)));
          write_reg(REG_ROWS, ($urandom_range(0, 1) == 0) ?
                    CFG_DATA_W'($urandom_range(1, 2048)) :
                    CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(REG_COLS, ($urandom_range(0, 1) == 0) ?
                    CFG_DATA_W'($urandom_range(1, 2048)) :
                    CFG_DATA_W'($urandom_range(0, 4095)));
        end
      endcase
      write_reg(IDX_SPARE_A, CFG_DATA_W'($urandom_range(0, 4095)));
      write_reg(IDX_SPARE_B, CFG_DATA_W'($urandom_range(0, 4095)));
      cfg_we_i <= 1'b0;

      // Phase 3 packs tiny frames against a stalled result port so the
      // frame queue fills and pixel ready drops.
      hold_req    = (phase_no == 3);
      steady      = hold_req || (phase_no % 4 == 2);
      phase_goal  = hold_req ? 40 : $urandom_range(30, 60);
      phase_items = 0;
      while (phase_items < phase_goal) begin
        if (hold_req) frame_len = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0) frame_len = $urandom_range(13, 60);
        else frame_len = $urandom_range(1, 12);
        for (int k = 0; k < frame_len; k++) begin
          p.blue      = channel_value(aim_cfg.blue_thr);
          p.green     = channel_value(aim_cfg.green_thr);
          p.red       = channel_value(aim_cfg.red_thr);
          p.row       = pick_pos(int'(aim_cfg.frame_rows >> 1), int'(aim_cfg.deadband) + 4);
          p.col       = pick_pos(int'(aim_cfg.frame_cols >> 1), int'(aim_cfg.deadband) + 4);
          p.frame_end = (k == frame_len - 1);
          if (!steady && !quiet_tail && $urandom_range(0, 3) == 0)
            idle_pixels($urandom_range(1, 17));
          send_pixel(p, 1'b0, '0);
          phase_items++;
        end
      end
      phase_no++;
    end

    // Drain: every predicted aim must show up, then watch for strays.
    pix.valid <= 1'b0;
    for (int n = 0; n < TAIL_LIMIT && pending_aims.size() != 0; n++) @(posedge clk_i);
    if (pending_aims.size() != 0) begin
      $error("%0d frame results never arrived", pending_aims.size());
      mismatches++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: ready in random bursts, one long hold-off on request,
  // and always ready in the quiet tail.
  initial begin : result_ready
    bit hold_done;
    hold_done = 1'b0;
    res.ready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (quiet_tail) begin
        res.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        if (!quiet_tail) begin
          res.ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk_i);
        end
      end
    end
  end

  // Compare each accepted result with the oldest predicted aim.
  always @(posedge clk_i) begin : check_aims
    aim_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_aims.size() == 0) begin
        $error("result item with none expected: command %0d hits %0d",
               res.command, res.hits);
        mismatches++;
      end else begin
        want = pending_aims.pop_front();
        if (res.command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, res.command);
          mismatches++;
        end
        if (res.centroid_row !== want.crow) begin
          $error("centroid_row: expected %0d, got %0d", want.crow, res.centroid_row);
          mismatches++;
        end
        if (res.centroid_col !== want.ccol) begin
          $error("centroid_col: expected %0d, got %0d", want.ccol, res.centroid_col);
          mismatches++;
        end
        if (res.hits !== want.hits) begin
          $error("hits: expected %0d, got %0d", want.hits, res.hits);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
